// ----- hw/rtl/tbik_pkg.sv -----
// Shared types, stage counts and per-stage step functions for the two-bone
// triangle solver pipeline. No dependencies.
`default_nettype none

package tbik_pkg;

  // Steps of each iterative unit, one register stage per step
  localparam int KD_STEPS = 17;  // base quotient k = |D| / 2S, low bits
  localparam int FB_STEPS = 16;  // straight-line quotient S*A / (A+B)
  localparam int CD_STEPS = 20;  // ceiling quotient for D^2 / 4S^2
  localparam int SQ_STEPS = 16;  // square-root digits

  // First divider stage: k and r, plus the fallback quotient alongside
  typedef struct packed {
    logic [16:0] rem;
    logic [16:0] quo;
    logic [16:0] dvd;
    logic [16:0] rem_f;
    logic [15:0] quo_f;
    logic [15:0] dvd_f;
    logic [15:0] a;
    logic [15:0] s;
    logic [16:0] sum;
    logic [31:0] aa;
    logic [31:0] ss;
    logic        zero;
    logic        fb;
  } kdiv_t;

  // Second divider stage: c = ceil(t / 4S^2)
  typedef struct packed {
    logic [33:0] rem;
    logic [19:0] quo;
    logic [19:0] dvd;
    logic [33:0] den;
    logic [33:0] kk;
    logic [31:0] aa;
    logic [15:0] fbq;
    logic        zero;
    logic        fb;
  } cdiv_t;

  // One square-root lane
  typedef struct packed {
    logic [31:0] v;
    logic [15:0] root;
    logic [17:0] rem;
  } sqs_t;

  typedef struct packed {
    sqs_t        h;
    sqs_t        x;
    logic [15:0] fbq;
    logic        zero;
    logic        fb;
  } sq_t;

  // One restoring step of both first-section dividers
  function automatic kdiv_t kdiv_step(kdiv_t d, logic do_f);
    logic [17:0] sh;
    logic [17:0] shf;
    logic [17:0] two_s;
    kdiv_t       n;
    n     = d;
    two_s = {1'b0, d.s, 1'b0};
    sh    = {d.rem, d.dvd[16]};
    n.dvd = {d.dvd[15:0], 1'b0};
    if (sh >= two_s) begin
      n.rem = 17'(sh - two_s);
      n.quo = {d.quo[15:0], 1'b1};
    end else begin
      n.rem = sh[16:0];
      n.quo = {d.quo[15:0], 1'b0};
    end
    if (do_f) begin
      shf     = {d.rem_f, d.dvd_f[15]};
      n.dvd_f = {d.dvd_f[14:0], 1'b0};
      if (shf >= {1'b0, d.sum}) begin
        n.rem_f = 17'(shf - {1'b0, d.sum});
        n.quo_f = {d.quo_f[14:0], 1'b1};
      end else begin
        n.rem_f = shf[16:0];
        n.quo_f = {d.quo_f[14:0], 1'b0};
      end
    end
    return n;
  endfunction

  // One restoring step of the ceiling divider
  function automatic cdiv_t cdiv_step(cdiv_t d);
    logic [34:0] sh;
    cdiv_t       n;
    n     = d;
    sh    = {d.rem, d.dvd[19]};
    n.dvd = {d.dvd[18:0], 1'b0};
    if (sh >= {1'b0, d.den}) begin
      n.rem = 34'(sh - {1'b0, d.den});
      n.quo = {d.quo[18:0], 1'b1};
    end else begin
      n.rem = sh[33:0];
      n.quo = {d.quo[18:0], 1'b0};
    end
    return n;
  endfunction

  // One digit of a floored square root, two radicand bits per step
  function automatic sqs_t sqs_step(sqs_t d);
    logic [19:0] acc;
    logic [19:0] trial;
    sqs_t        n;
    acc    = {d.rem, d.v[31:30]};
    trial  = {2'b00, d.root, 2'b01};
    n.v    = {d.v[29:0], 2'b00};
    if (acc >= trial) begin
      n.rem  = 18'(acc - trial);
      n.root = {d.root[14:0], 1'b1};
    end else begin
      n.rem  = acc[17:0];
      n.root = {d.root[14:0], 1'b0};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tbik_if.sv -----
// Valid/ready channel interfaces for the solver's input and result beats.
// Depends on nothing.
`default_nettype none

interface tbik_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] upper_length;
  logic [15:0] lower_length;
  logic [15:0] target_distance;

  modport source (output valid, upper_length, lower_length, target_distance,
                  input ready);
  modport sink   (input valid, upper_length, lower_length, target_distance,
                  output ready);
endinterface

interface tbik_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hinge_height;
  logic [15:0] along_distance;
  logic        reached;

  modport source (output valid, hinge_height, along_distance, reached,
                  input ready);
  modport sink   (input valid, hinge_height, along_distance, reached,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/two_bone_ik_triangle_solver.sv -----
// Two-bone triangle solver, one input beat accepted per cycle unless a held
// result stalls it. The pipeline holds the 17-step and 20-step restoring
// dividers, the 16-step square roots, six multiply/add stages and the result
// register. All stages stall together when the result is held.
// rst_n (synchronous) clears every valid bit; payload registers keep data.
`default_nettype none

module two_bone_ik_triangle_solver (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tbik_in_if.sink     in_ch,
  tbik_out_if.source  out_ch
);

  localparam int KD = tbik_pkg::KD_STEPS;
  localparam int CD = tbik_pkg::CD_STEPS;
  localparam int SQ = tbik_pkg::SQ_STEPS;

  logic adv;

  // Stage 1: squares and the fallback product
  logic        s1_v_r;
  logic [15:0] s1_a_r, s1_s_r;
  logic [16:0] s1_sum_r;
  logic [31:0] s1_aa_r, s1_bb_r, s1_ss_r, s1_sa_r;
  logic        s1_zero_r, s1_far_r;
  logic [16:0] s1_sum_nxt;

  // Stage 2: |D|
  logic        s2_v_r;
  logic [15:0] s2_a_r, s2_s_r;
  logic [16:0] s2_sum_r;
  logic [31:0] s2_aa_r, s2_ss_r, s2_sa_r;
  logic [33:0] s2_q_r;
  logic        s2_zero_r, s2_far_r;
  logic [34:0] s2_d_nxt;

  // First dividers
  tbik_pkg::kdiv_t kd_init;
  tbik_pkg::kdiv_t kd_nxt [KD];
  tbik_pkg::kdiv_t kd_r   [KD];
  logic [KD-1:0]   kd_v_r;

  // Multiply stages
  logic        m1_v_r, m2_v_r, n_v_r;
  logic [32:0] m1_sk_r;
  logic [33:0] m1_rr_r, m1_kk_r, m2_rr_r, m2_kk_r;
  logic [16:0] m1_r_r;
  logic [31:0] m1_aa_r, m1_ss_r, m2_aa_r, m2_ss_r;
  logic [15:0] m1_fbq_r, m2_fbq_r;
  logic        m1_zero_r, m1_fb_r, m2_zero_r, m2_fb_r;
  logic [49:0] m2_skr_r;
  tbik_pkg::kdiv_t kd_last;
  logic [53:0] n_num;

  // Second divider
  tbik_pkg::cdiv_t cd_init_r;
  tbik_pkg::cdiv_t cd_nxt [CD];
  tbik_pkg::cdiv_t cd_r   [CD];
  logic [CD-1:0]   cd_v_r;

  // Subtraction and square roots
  tbik_pkg::sq_t sq_init_r;
  logic          sb_v_r;
  tbik_pkg::sq_t sq_nxt [SQ];
  tbik_pkg::sq_t sq_r   [SQ];
  logic [SQ-1:0] sq_v_r;
  logic [34:0]   sb_sub;

  // Result register
  logic        out_v_r;
  logic [15:0] out_h_r, out_x_r;
  logic        out_reached_r;

  // Advance the whole pipeline unless a finished result is held
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Valid bits shift with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      kd_v_r  <= '0;
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      n_v_r   <= 1'b0;
      cd_v_r  <= '0;
      sb_v_r  <= 1'b0;
      sq_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_ch.valid;
      s2_v_r  <= s1_v_r;
      kd_v_r  <= {kd_v_r[KD-2:0], s2_v_r};
      m1_v_r  <= kd_v_r[KD-1];
      m2_v_r  <= m1_v_r;
      n_v_r   <= m2_v_r;
      cd_v_r  <= {cd_v_r[CD-2:0], n_v_r};
      sb_v_r  <= cd_v_r[CD-1];
      sq_v_r  <= {sq_v_r[SQ-2:0], sb_v_r};
      out_v_r <= sq_v_r[SQ-1];
    end
  end

  // Stage 1 payload
  assign s1_sum_nxt = {1'b0, in_ch.upper_length} + {1'b0, in_ch.lower_length};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r    <= in_ch.upper_length;
      s1_s_r    <= in_ch.target_distance;
      s1_sum_r  <= s1_sum_nxt;
      s1_aa_r   <= in_ch.upper_length * in_ch.upper_length;
      s1_bb_r   <= in_ch.lower_length * in_ch.lower_length;
      s1_ss_r   <= in_ch.target_distance * in_ch.target_distance;
      s1_sa_r   <= in_ch.target_distance * in_ch.upper_length;
      s1_zero_r <= (in_ch.target_distance == 16'd0) || (s1_sum_nxt == 17'd0);
      s1_far_r  <= s1_sum_nxt < {1'b0, in_ch.target_distance};
    end
  end

  // Stage 2 payload: D = A^2 + S^2 - B^2, keep its magnitude
  assign s2_d_nxt = {3'b000, s1_aa_r} + {3'b000, s1_ss_r} - {3'b000, s1_bb_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a_r    <= s1_a_r;
      s2_s_r    <= s1_s_r;
      s2_sum_r  <= s1_sum_r;
      s2_aa_r   <= s1_aa_r;
      s2_ss_r   <= s1_ss_r;
      s2_sa_r   <= s1_sa_r;
      s2_zero_r <= s1_zero_r;
      s2_far_r  <= s1_far_r;
      s2_q_r    <= s2_d_nxt[34] ? 34'(-s2_d_nxt) : s2_d_nxt[33:0];
    end
  end

  // Load the first dividers; a quotient past 17 bits already exceeds A
  always_comb begin
    kd_init       = '0;
    kd_init.rem   = s2_q_r[33:17];
    kd_init.dvd   = s2_q_r[16:0];
    kd_init.rem_f = {1'b0, s2_sa_r[31:16]};
    kd_init.dvd_f = s2_sa_r[15:0];
    kd_init.a     = s2_a_r;
    kd_init.s     = s2_s_r;
    kd_init.sum   = s2_sum_r;
    kd_init.aa    = s2_aa_r;
    kd_init.ss    = s2_ss_r;
    kd_init.zero  = s2_zero_r;
    kd_init.fb    = s2_far_r || (s2_q_r[33:17] >= {s2_s_r, 1'b0});
  end

  always_comb begin
    kd_nxt[0] = tbik_pkg::kdiv_step(kd_init, 1'b1);
    for (int i = 1; i < KD; i++) begin
      kd_nxt[i] = tbik_pkg::kdiv_step(kd_r[i-1], i < tbik_pkg::FB_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < KD; i++) begin
        kd_r[i] <= kd_nxt[i];
      end
    end
  end

  // Products S*k, r^2, k^2; drop to fallback when k exceeds A
  assign kd_last = kd_r[KD-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sk_r   <= {17'd0, kd_last.s} * {16'd0, kd_last.quo};
      m1_rr_r   <= {17'd0, kd_last.rem} * {17'd0, kd_last.rem};
      m1_kk_r   <= {17'd0, kd_last.quo} * {17'd0, kd_last.quo};
      m1_r_r    <= kd_last.rem;
      m1_aa_r   <= kd_last.aa;
      m1_ss_r   <= kd_last.ss;
      m1_fbq_r  <= kd_last.quo_f;
      m1_zero_r <= kd_last.zero;
      m1_fb_r   <= kd_last.fb || (kd_last.quo > {1'b0, kd_last.a});
    end
  end

  // Product S*k*r
  always_ff @(posedge clk) begin
    if (adv) begin
      m2_skr_r  <= {17'd0, m1_sk_r} * {33'd0, m1_r_r};
      m2_rr_r   <= m1_rr_r;
      m2_kk_r   <= m1_kk_r;
      m2_aa_r   <= m1_aa_r;
      m2_ss_r   <= m1_ss_r;
      m2_fbq_r  <= m1_fbq_r;
      m2_zero_r <= m1_zero_r;
      m2_fb_r   <= m1_fb_r;
    end
  end

  // Numerator t + 4S^2 - 1 for the ceiling quotient
  assign n_num = {2'b00, m2_skr_r, 2'b00} + {20'd0, m2_rr_r}
               + {20'd0, m2_ss_r, 2'b00} - 54'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_init_r.rem  <= n_num[53:20];
      cd_init_r.dvd  <= n_num[19:0];
      cd_init_r.quo  <= '0;
      cd_init_r.den  <= {m2_ss_r, 2'b00};
      cd_init_r.kk   <= m2_kk_r;
      cd_init_r.aa   <= m2_aa_r;
      cd_init_r.fbq  <= m2_fbq_r;
      cd_init_r.zero <= m2_zero_r;
      cd_init_r.fb   <= m2_fb_r;
    end
  end

  // Ceiling divider stages
  always_comb begin
    cd_nxt[0] = tbik_pkg::cdiv_step(cd_init_r);
    for (int i = 1; i < CD; i++) begin
      cd_nxt[i] = tbik_pkg::cdiv_step(cd_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < CD; i++) begin
        cd_r[i] <= cd_nxt[i];
      end
    end
  end

  // sub = k^2 + c; negative squared height when sub exceeds A^2
  assign sb_sub = {1'b0, cd_r[CD-1].kk} + {15'd0, cd_r[CD-1].quo};

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_init_r.h.v    <= cd_r[CD-1].aa - sb_sub[31:0];
      sq_init_r.h.root <= '0;
      sq_init_r.h.rem  <= '0;
      sq_init_r.x.v    <= sb_sub[31:0];
      sq_init_r.x.root <= '0;
      sq_init_r.x.rem  <= '0;
      sq_init_r.fbq    <= cd_r[CD-1].fbq;
      sq_init_r.zero   <= cd_r[CD-1].zero;
      sq_init_r.fb     <= cd_r[CD-1].fb || (sb_sub > {3'b000, cd_r[CD-1].aa});
    end
  end

  // Square-root stages, height and base lanes side by side
  always_comb begin
    sq_nxt[0]   = sq_init_r;
    sq_nxt[0].h = tbik_pkg::sqs_step(sq_init_r.h);
    sq_nxt[0].x = tbik_pkg::sqs_step(sq_init_r.x);
    for (int i = 1; i < SQ; i++) begin
      sq_nxt[i]   = sq_r[i-1];
      sq_nxt[i].h = tbik_pkg::sqs_step(sq_r[i-1].h);
      sq_nxt[i].x = tbik_pkg::sqs_step(sq_r[i-1].x);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < SQ; i++) begin
        sq_r[i] <= sq_nxt[i];
      end
    end
  end

  // Select solved, straight-line or zero result
  always_ff @(posedge clk) begin
    if (adv) begin
      out_h_r       <= (sq_r[SQ-1].fb || sq_r[SQ-1].zero) ? 16'd0 : sq_r[SQ-1].h.root;
      out_x_r       <= sq_r[SQ-1].zero ? 16'd0 :
                       (sq_r[SQ-1].fb ? sq_r[SQ-1].fbq : sq_r[SQ-1].x.root);
      out_reached_r <= !(sq_r[SQ-1].fb || sq_r[SQ-1].zero);
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.hinge_height   = out_h_r;
  assign out_ch.along_distance = out_x_r;
  assign out_ch.reached        = out_reached_r;

endmodule

`default_nettype wire

// ----- verif/tbik_tb_if.sv -----
// Testbench-side note: the channel interfaces come from the RTL (tbik_if.sv).
// This file holds the testbench's shared beat types; depends on nothing.
`timescale 1ns / 1ps

package tbik_tb_pkg;
  typedef struct packed {
    logic [15:0] upper_length;
    logic [15:0] lower_length;
    logic [15:0] target_distance;
  } limb_beat_t;

  typedef struct packed {
    logic [15:0] hinge_height;
    logic [15:0] along_distance;
    logic        reached;
  } hinge_beat_t;
endpackage

// ----- verif/tbik_checker.sv -----
// Checker for the two-bone triangle solver: watches both channels, predicts
// each result from the input beat and compares in order. Depends on tbik_tb_pkg and the RTL channel interfaces.
`timescale 1ns / 1ps

module tbik_checker
  import tbik_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tbik_in_if.sink     in_mon,
  tbik_out_if.sink    out_mon,
  output int          fail_count,
  output int          pending_count
);

  hinge_beat_t pending_hinges[$];

  // Floored square root, bit by bit
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Place the hinge for one limb beat
  function automatic hinge_beat_t solve_hinge(limb_beat_t lb);
    logic [63:0] a, b, s, sum, q, k, r, four_ss, t, c, sub;
    longint      d;
    logic        fallback;
    hinge_beat_t hb;
    a   = lb.upper_length;
    b   = lb.lower_length;
    s   = lb.target_distance;
    sum = a + b;
    hb  = '0;
    if (s != 0 && sum != 0) begin
      fallback = sum < s;
      if (!fallback) begin
        d = longint'(a * a) + longint'(s * s) - longint'(b * b);
        q = (d < 0) ? -d : d;
        k = q / (2 * s);
        r = q % (2 * s);
        if (k > a) begin
          fallback = 1'b1;
        end else begin
          four_ss = 4 * s * s;
          t   = 4 * s * k * r + r * r;
          c   = (t + four_ss - 1) / four_ss;
          sub = k * k + c;
          if (sub > a * a) begin
            fallback = 1'b1;
          end else begin
            hb.hinge_height   = 16'(floor_root(a * a - sub));
            hb.along_distance = 16'(floor_root(sub));
            hb.reached        = 1'b1;
          end
        end
      end
      if (fallback) begin
        hb.hinge_height   = '0;
        hb.along_distance = 16'((s * a) / sum);
        hb.reached        = 1'b0;
      end
    end
    return hb;
  endfunction

  assign pending_count = pending_hinges.size();

  // Predict on input beats, compare on result beats
  always @(posedge clk) begin
    hinge_beat_t want;
    limb_beat_t  lb;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        lb = {in_mon.upper_length, in_mon.lower_length, in_mon.target_distance};
        pending_hinges.push_back(solve_hinge(lb));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_hinges.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat h=%0d x=%0d r=%0d",
            out_mon.hinge_height, out_mon.along_distance, out_mon.reached);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_hinges.pop_front();
          if (want.hinge_height !== out_mon.hinge_height ||
              want.along_distance !== out_mon.along_distance ||
              want.reached !== out_mon.reached) begin
            if (fail_count < 10)
              $display("result beat differs: want h=%0d x=%0d r=%0d got h=%0d x=%0d r=%0d",
                want.hinge_height, want.along_distance, want.reached,
                out_mon.hinge_height, out_mon.along_distance, out_mon.reached);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- verif/two_bone_ik_triangle_solver_test.sv -----
// Stimulus and verdict for the two-bone triangle solver. Depends on the solver,
// the RTL channel interfaces, tbik_tb_pkg and tbik_checker.
`timescale 1ns / 1ps

module two_bone_ik_triangle_solver_test;
  import tbik_tb_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_off;

  tbik_in_if  in_ch ();
  tbik_out_if out_ch ();

  two_bone_ik_triangle_solver u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  tbik_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch.sink),
    .out_mon       (out_ch.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result-side ready: random stalls, or a long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one beat, wait for acceptance
  task automatic send_limb(input limb_beat_t lb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.upper_length    <= lb.upper_length;
    in_ch.lower_length    <= lb.lower_length;
    in_ch.target_distance <= lb.target_distance;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly reachable triangles, some out of reach, some raw noise
  function automatic limb_beat_t random_limb();
    limb_beat_t lb;
    int         pick;
    pick = $urandom_range(9);
    lb.upper_length = (pick < 3) ? 16'($urandom_range(255)) : 16'($urandom);
    lb.lower_length = (pick < 3) ? 16'($urandom_range(255)) : 16'($urandom);
    if (pick < 7) begin
      lb.target_distance = 16'($urandom_range(
        (lb.upper_length + lb.lower_length > 65535) ? 65535
          : lb.upper_length + lb.lower_length));
    end else begin
      lb.target_distance = 16'($urandom);
    end
    return lb;
  endfunction

  task automatic random_phase(input int count);
    repeat (count) send_limb(random_limb());
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    limb_beat_t edge_limbs[$];
    in_ch.valid <= 1'b0;
    in_ch.upper_length <= '0;
    in_ch.lower_length <= '0;
    in_ch.target_distance <= '0;
    hold_off = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 74;
    rst_n <= 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero target, zero bones, extremes, degenerate triangles
    edge_limbs = '{
      '{16'd0, 16'd0, 16'd0}, '{16'd256, 16'd256, 16'd0},
      '{16'd0, 16'd0, 16'd100}, '{16'd100, 16'd100, 16'd500},
      '{16'd256, 16'd256, 16'd256}, '{16'd300, 16'd400, 16'd500},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'hFFFF, 16'd1},
      '{16'hFFFF, 16'd0, 16'hFFFF}, '{16'd0, 16'hFFFF, 16'hFFFF},
      '{16'd1000, 16'd10, 16'd5}, '{16'd10, 16'd1000, 16'd5},
      '{16'd1, 16'd1, 16'd2}, '{16'd1, 16'd1, 16'd1},
      '{16'd5, 16'd3, 16'd8}, '{16'hAAAA, 16'h5555, 16'hFFFF},
      '{16'h5555, 16'hAAAA, 16'h8000}, '{16'd0, 16'd500, 16'd500},
      '{16'd500, 16'd0, 16'd400}, '{16'hFFFF, 16'd1, 16'hFFFF}
    };
    foreach (edge_limbs[i]) send_limb(edge_limbs[i]);
    random_phase(480);

    // Long receiver hold-off while input keeps coming
    hold_off = 1'b1;
    fork
      begin
        int held;
        for (held = 0; held < 300; held++) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(120);
    join

    send_idle_pct = 74;
    recv_idle_pct = 10;
    random_phase(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(410);

    while (pending_count != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0) $display("two_bone_ik_triangle_solver: match");
    else $display("two_bone_ik_triangle_solver: mismatch");
    $finish;
  end

  initial begin
    #3000000;
    $display("two_bone_ik_triangle_solver: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tbik_pkg.sv
hw/rtl/tbik_if.sv
hw/rtl/two_bone_ik_triangle_solver.sv
verif/tbik_tb_if.sv
verif/tbik_checker.sv
verif/two_bone_ik_triangle_solver_test.sv
